>>> design/oal_pkg.sv
`default_nettype none

package oal_pkg;

    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_LOCATE = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_cell_op;

    // broadcast from the control to every cell of the row
    typedef struct packed {
        t_cell_op           op;
        logic               probe;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   count;
        logic [WORD_W-1:0]  value;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> design/oal_cell.sv
`default_nettype none

module oal_cell
    import oal_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [WORD_W-1:0] i_left,
    input  wire logic [WORD_W-1:0] i_right,
    output logic [WORD_W-1:0]      o_data,
    output logic                   o_hit,
    output logic [WORD_W-1:0]      o_pick
);

    localparam logic [IDX_W-1:0] L_IDX = IDX_W'(IDX);

    logic [WORD_W-1:0] r_data;
    logic              r_hit;
    logic [WORD_W-1:0] r_pick;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_INSERT: begin
                if (L_IDX > i_ctl.idx) begin
                    r_data <= i_left;
                end else if (L_IDX == i_ctl.idx) begin
                    r_data <= i_ctl.value;
                end
            end
            OP_DELETE: begin
                if (L_IDX >= i_ctl.idx) begin
                    r_data <= i_right;
                end
            end
            default: begin
            end
        endcase
        // compare and select run on the contents before this request
        if (i_ctl.probe) begin
            r_hit  <= (r_data == i_ctl.value) && ({1'b0, L_IDX} < i_ctl.count);
            r_pick <= (L_IDX == i_ctl.idx) ? r_data : '0;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;
    assign o_pick = r_pick;

endmodule

`default_nettype wire

>>> design/ordered_array_list_core.sv
// a result is registered in the cells when its request is accepted and then in the
// output registers, held back only while the previous result is held under stall
// a new request is taken only back in S_IDLE, after the last result is loaded; the row
// of cells shifts and compares all entries in the accept cycle, S_EVAL merges the outputs
// reset: clears the entry count and all handshake state; entries are not cleared
`default_nettype none

module ordered_array_list_core
    import oal_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_position,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_found_index,
    output logic [31:0]      o_read_value,
    output logic [4:0]       o_count
);

    localparam logic [CNT_W-1:0] L_DEPTH = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_kind             r_kind;
    t_status           r_pre_status, n_pre_status;
    logic [4:0]        r_res_count;
    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [3:0]        r_found_index;
    logic [31:0]       r_read_value;
    logic [4:0]        r_o_count;

    t_cell_ctl         w_ctl;
    logic [CNT_W-1:0]  w_pos;
    logic              w_accept;
    logic              w_load;
    logic              w_any;
    logic [IDX_W-1:0]  w_first;
    logic [WORD_W-1:0] w_pick_or;
    t_status           w_status;

    logic [WORD_W-1:0] w_data [DEPTH];
    logic [WORD_W-1:0] w_pick [DEPTH];
    logic [DEPTH-1:0]  w_hit;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_pos      = {1'b0, i_position};

    // request check against the count held before the request
    always_comb begin
        n_pre_status = ST_OK;
        n_count      = r_count;
        w_ctl.op     = OP_HOLD;
        w_ctl.probe  = w_accept;
        w_ctl.idx    = i_position - 8'd1;
        w_ctl.count  = r_count;
        w_ctl.value  = i_value;
        case (t_kind'(i_kind))
            K_INSERT: begin
                if (r_count >= L_DEPTH) begin
                    n_pre_status = ST_FULL;
                end else if (i_position == 8'd0 || w_pos > r_count + 1'b1) begin
                    n_pre_status = ST_BADPOS;
                end else begin
                    w_ctl.op = w_accept ? OP_INSERT : OP_HOLD;
                    n_count  = r_count + 1'b1;
                end
            end
            K_DELETE: begin
                if (r_count == '0) begin
                    n_pre_status = ST_EMPTY;
                end else if (i_position == 8'd0 || w_pos > r_count) begin
                    n_pre_status = ST_BADPOS;
                end else begin
                    w_ctl.op = w_accept ? OP_DELETE : OP_HOLD;
                    n_count  = r_count - 1'b1;
                end
            end
            K_READ: begin
                if (i_position == 8'd0 || w_pos > r_count) begin
                    n_pre_status = ST_BADPOS;
                end
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_W-1:0] w_left;
            logic [WORD_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = i_value;
            end else begin : g_mid
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_inner
                assign w_right = w_data[g+1];
            end
            oal_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_hit   (w_hit[g]),
                .o_pick  (w_pick[g])
            );
        end
    endgenerate

    // merge the registered cell outputs
    always_comb begin
        w_any     = 1'b0;
        w_first   = '0;
        w_pick_or = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                w_any   = 1'b1;
                w_first = IDX_W'(k);
            end
        end
        for (int k = 0; k < DEPTH; k++) begin
            w_pick_or = w_pick_or | w_pick[k];
        end
        w_status = r_pre_status;
        if (r_kind == K_LOCATE && !w_any) begin
            w_status = ST_NOTFOUND;
        end
    end

    assign w_load = (r_state == S_EVAL) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_EVAL;
            S_EVAL: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind       <= t_kind'(i_kind);
            r_pre_status <= n_pre_status;
            r_res_count  <= n_count[4:0];
        end
        if (w_load) begin
            r_status      <= w_status;
            r_found_index <= (r_kind == K_LOCATE && w_any) ? w_first[3:0] : 4'd0;
            r_read_value  <= (r_kind == K_READ && r_pre_status == ST_OK) ? w_pick_or : '0;
            r_o_count     <= r_res_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found_index;
    assign o_read_value  = r_read_value;
    assign o_count       = r_o_count;

endmodule

`default_nettype wire

>>> design/oal_checker.sv
`default_nettype none

module oal_checker
    import oal_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_status,
    input wire logic [3:0]  o_found_index,
    input wire logic [31:0] o_read_value,
    input wire logic [4:0]  o_count
);

    // after a request is accepted, the input is stalled in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted without a busy cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_count) && $stable(o_read_value)))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_found_index == 4'd0
            && o_read_value == 32'd0))
        else $error("failed request carries nonzero index or data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_count == 5'd0))
        else $error("empty status with nonzero count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_FULL
            || o_status == ST_EMPTY || o_status == ST_BADPOS
            || o_status == ST_NOTFOUND))
        else $error("undefined status code");

endmodule

bind ordered_array_list_core oal_checker u_oal_checker (.*);

`default_nettype wire
